/* rtl/sasrs_pkg.sv */
`default_nettype none
package sasrs_pkg;

  localparam int ANGLE_BITS  = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] READ_BIT   = 16'h4000;
  localparam logic [15:0] PARITY_BIT = 16'h8000;
  localparam logic [ANGLE_BITS-1:0] ADDR_ANGLE = 14'h3FFF;
  localparam logic [ANGLE_BITS-1:0] ADDR_DIAG  = 14'h3FFC;
  localparam logic [ANGLE_BITS-1:0] ADDR_ERROR = 14'h0001;
  localparam logic [ANGLE_BITS-1:0] FIELD_MASK = 14'h0F00;
  localparam logic [ANGLE_BITS-1:0] FIELD_GOOD = 14'h0100;
  localparam int FLAG_POS = 14;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_FRAME   = 2'd1,
    OP_FAULT   = 2'd2,
    OP_RECOVER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_REQUEST  = 2'd1,
    PH_RESPONSE = 2'd2,
    PH_FAILED   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEL_ANGLE = 2'd0,
    SEL_DIAG  = 2'd1,
    SEL_ERROR = 2'd2
  } sel_t;

  typedef enum logic [3:0] {
    ST_IGNORED   = 4'd0,
    ST_CMD       = 4'd1,
    ST_NOP       = 4'd2,
    ST_ANGLE     = 4'd3,
    ST_DIAG_OK   = 4'd4,
    ST_DIAG_BAD  = 4'd5,
    ST_ERRREG    = 4'd6,
    ST_PARITY    = 4'd7,
    ST_FLAG      = 4'd8,
    ST_BUSY      = 4'd9,
    ST_TIMEOUT   = 4'd10,
    ST_FAULT     = 4'd11,
    ST_RECOVERED = 4'd12,
    ST_BUSY_WAIT = 4'd13
  } status_t;

  typedef enum logic [1:0] {
    CFG_DIAG_PERIOD = 2'd0,
    CFG_TIMEOUT     = 2'd1,
    CFG_POLE_PAIRS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] diag_period_ms;
    logic [31:0] timeout_cycles;
    logic [6:0]  pole_pairs;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                   op;
    logic                  rx_odd;
    logic                  rx_flag;
    logic [ANGLE_BITS-1:0] rx_data;
    logic [31:0]           now_ms;
    logic [31:0]           now_cycles;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                  tx_send;
    logic [15:0]           tx_word;
    status_t               status;
    logic [ANGLE_BITS-1:0] sample_raw;
    logic [ANGLE_BITS-1:0] electrical_angle;
    logic                  sample_valid;
    logic [31:0]           sequence_res;
    logic [ANGLE_BITS-1:0] diag_value;
    logic [ANGLE_BITS-1:0] errreg_value;
  } res_t;

  function automatic logic odd16(input logic [15:0] w);
    return ^w;
  endfunction

endpackage
`default_nettype wire

/* rtl/sasrs_front.sv */
`default_nettype none
module sasrs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic [15:0]        rx_word,
  input  wire logic [31:0]        now_ms,
  input  wire logic [31:0]        now_cycles,
  input  wire sasrs_pkg::q_status_t q_stat,
  output logic                    push,
  output sasrs_pkg::req_t         push_data,
  output logic                    front_valid
);

  sasrs_pkg::req_t req;
  logic            accept;

  assign in_stall  = front_valid && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = front_valid && !q_stat.full;
  assign push_data = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  // decode the event and check the received word up front
  always_ff @(posedge clk) begin
    if (accept) begin
      req.op         <= sasrs_pkg::op_t'(func);
      req.rx_odd     <= sasrs_pkg::odd16(rx_word);
      req.rx_flag    <= rx_word[sasrs_pkg::FLAG_POS];
      req.rx_data    <= rx_word[sasrs_pkg::ANGLE_BITS-1:0];
      req.now_ms     <= now_ms;
      req.now_cycles <= now_cycles;
    end
  end

endmodule
`default_nettype wire

/* rtl/sasrs_fifo.sv */
`default_nettype none
module sasrs_fifo #(
  parameter int DEPTH = sasrs_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sasrs_pkg::req_t      push_data,
  input  wire logic                 pop,
  output sasrs_pkg::req_t           pop_data,
  output sasrs_pkg::q_status_t      q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sasrs_pkg::req_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/sasrs_back.sv */
`default_nettype none
module sasrs_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sasrs_pkg::cfg_t      cfg,
  input  wire sasrs_pkg::req_t      req,
  input  wire sasrs_pkg::q_status_t q_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sasrs_pkg::res_t           res
);

  localparam int AB = sasrs_pkg::ANGLE_BITS;

  sasrs_pkg::phase_t phase, phase_next;
  sasrs_pkg::sel_t   reg_selected, reg_selected_next;
  logic              error_read_pending, error_read_pending_next;
  logic              diag_good, diag_good_next;
  logic [31:0]       diag_read_ms, diag_read_ms_next;
  logic [31:0]       start_time, start_time_next;
  logic [AB-1:0]     raw_store, raw_store_next;
  logic [AB-1:0]     elec_store, elec_store_next;
  logic              valid_store, valid_store_next;
  logic [31:0]       seq_count, seq_count_next;
  logic [AB-1:0]     diag_store, diag_store_next;
  logic [AB-1:0]     errflag_store, errflag_store_next;

  logic              send;
  logic [15:0]       word;
  logic [15:0]       cmd;
  sasrs_pkg::status_t status;
  logic [31:0]       age_ms;
  logic [31:0]       age_cycles;
  logic [AB+6:0]     product;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= sasrs_pkg::PH_IDLE;
      reg_selected       <= sasrs_pkg::SEL_ANGLE;
      error_read_pending <= 1'b0;
      diag_good          <= 1'b0;
      diag_read_ms       <= '0;
      start_time         <= '0;
      raw_store          <= '0;
      elec_store         <= '0;
      valid_store        <= 1'b0;
      seq_count          <= '0;
      diag_store         <= '0;
      errflag_store      <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (pop) begin
        phase              <= phase_next;
        reg_selected       <= reg_selected_next;
        error_read_pending <= error_read_pending_next;
        diag_good          <= diag_good_next;
        diag_read_ms       <= diag_read_ms_next;
        start_time         <= start_time_next;
        raw_store          <= raw_store_next;
        elec_store         <= elec_store_next;
        valid_store        <= valid_store_next;
        seq_count          <= seq_count_next;
        diag_store         <= diag_store_next;
        errflag_store      <= errflag_store_next;
        out_valid          <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.tx_send          <= send;
      res.tx_word          <= word;
      res.status           <= status;
      res.sample_raw       <= raw_store_next;
      res.electrical_angle <= elec_store_next;
      res.sample_valid     <= valid_store_next;
      res.sequence_res     <= seq_count_next;
      res.diag_value       <= diag_store_next;
      res.errreg_value     <= errflag_store_next;
    end
  end

  assign age_ms     = req.now_ms - diag_read_ms;
  assign age_cycles = req.now_cycles - start_time;
  assign product    = {7'b0, req.rx_data} * {{AB{1'b0}}, cfg.pole_pairs};

  always_comb begin
    phase_next              = phase;
    reg_selected_next       = reg_selected;
    error_read_pending_next = error_read_pending;
    diag_good_next          = diag_good;
    diag_read_ms_next       = diag_read_ms;
    start_time_next         = start_time;
    raw_store_next          = raw_store;
    elec_store_next         = elec_store;
    valid_store_next        = valid_store;
    seq_count_next          = seq_count;
    diag_store_next         = diag_store;
    errflag_store_next      = errflag_store;
    send                    = 1'b0;
    word                    = '0;
    cmd                     = '0;
    status                  = sasrs_pkg::ST_IGNORED;

    unique case (req.op)
      sasrs_pkg::OP_TICK: begin
        unique case (phase)
          sasrs_pkg::PH_IDLE: begin
            // pick register: pending error read, bad/stale diagnostic, else angle
            if (error_read_pending) begin
              reg_selected_next       = sasrs_pkg::SEL_ERROR;
              cmd                     = sasrs_pkg::READ_BIT | {2'b0, sasrs_pkg::ADDR_ERROR};
              error_read_pending_next = 1'b0;
            end else if (!diag_good || age_ms >= {16'b0, cfg.diag_period_ms}) begin
              reg_selected_next = sasrs_pkg::SEL_DIAG;
              cmd               = sasrs_pkg::READ_BIT | {2'b0, sasrs_pkg::ADDR_DIAG};
            end else begin
              reg_selected_next = sasrs_pkg::SEL_ANGLE;
              cmd               = sasrs_pkg::READ_BIT | {2'b0, sasrs_pkg::ADDR_ANGLE};
            end
            word            = sasrs_pkg::odd16(cmd) ? (cmd | sasrs_pkg::PARITY_BIT) : cmd;
            send            = 1'b1;
            start_time_next = req.now_cycles;
            phase_next      = sasrs_pkg::PH_REQUEST;
            status          = sasrs_pkg::ST_CMD;
          end
          sasrs_pkg::PH_FAILED: begin
            status = sasrs_pkg::ST_BUSY_WAIT;
          end
          default: begin
            if (age_cycles > cfg.timeout_cycles) begin
              valid_store_next = 1'b0;
              diag_good_next   = 1'b0;
              phase_next       = sasrs_pkg::PH_FAILED;
              status           = sasrs_pkg::ST_TIMEOUT;
            end else begin
              status = sasrs_pkg::ST_BUSY;
            end
          end
        endcase
      end
      sasrs_pkg::OP_FRAME: begin
        unique case (phase)
          sasrs_pkg::PH_REQUEST: begin
            phase_next = sasrs_pkg::PH_RESPONSE;
            send       = 1'b1;
            status     = sasrs_pkg::ST_NOP;
          end
          sasrs_pkg::PH_RESPONSE: begin
            if (req.rx_odd) begin
              valid_store_next = 1'b0;
              diag_good_next   = 1'b0;
              status           = sasrs_pkg::ST_PARITY;
            end else if (reg_selected == sasrs_pkg::SEL_ERROR) begin
              errflag_store_next = req.rx_data;
              diag_good_next     = 1'b0;
              status             = sasrs_pkg::ST_ERRREG;
            end else if (req.rx_flag) begin
              valid_store_next        = 1'b0;
              diag_good_next          = 1'b0;
              error_read_pending_next = 1'b1;
              status                  = sasrs_pkg::ST_FLAG;
            end else if (reg_selected == sasrs_pkg::SEL_DIAG) begin
              diag_store_next   = req.rx_data;
              diag_read_ms_next = req.now_ms;
              if ((req.rx_data & sasrs_pkg::FIELD_MASK) == sasrs_pkg::FIELD_GOOD) begin
                diag_good_next = 1'b1;
                status         = sasrs_pkg::ST_DIAG_OK;
              end else begin
                diag_good_next   = 1'b0;
                valid_store_next = 1'b0;
                status           = sasrs_pkg::ST_DIAG_BAD;
              end
            end else begin
              raw_store_next   = req.rx_data;
              elec_store_next  = product[AB-1:0];
              valid_store_next = diag_good;
              seq_count_next   = seq_count + 32'd1;
              status           = sasrs_pkg::ST_ANGLE;
            end
            phase_next = sasrs_pkg::PH_IDLE;
          end
          default: begin
            status = sasrs_pkg::ST_IGNORED;
          end
        endcase
      end
      sasrs_pkg::OP_FAULT: begin
        valid_store_next = 1'b0;
        diag_good_next   = 1'b0;
        phase_next       = sasrs_pkg::PH_FAILED;
        status           = sasrs_pkg::ST_FAULT;
      end
      default: begin
        if (phase == sasrs_pkg::PH_FAILED) begin
          phase_next = sasrs_pkg::PH_IDLE;
          status     = sasrs_pkg::ST_RECOVERED;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/spi_angle_sensor_read_sequencer.sv */
// Read sequencer for a two-frame SPI angle sensor.
// Input channel (in_valid/in_stall) carries one event per request: func
// selects sample tick, frame complete, link fault or recover; rx_word,
// now_ms and now_cycles go with it. Every request yields exactly one result
// on the output channel (out_valid/out_stall): the frame to start, if any
// (tx_send/tx_word), a status code and the published sample, diagnostic
// and error register copies.
// With no stall, an accepted request passes from the front register through
// the queue to the result register, where out_valid rises. One request per
// cycle is taken while out_stall stays low: the front stage decodes the
// event and checks rx parity, a short queue decouples it from the back
// stage, whose state update and output register set the rate.
// When the receiver stalls, the result is held; the queue and the front
// register take up to three more requests before in_stall rises.
// Reset puts the sequencer idle with the angle register selected, clears
// all stored values and loads the registers: diag_period_ms 100,
// timeout_cycles 34000, pole_pairs 7. The user writes them over the APB
// port at bytes 0, 4 and 8 only while the block is idle; it is not enforced.
`default_nettype none
module spi_angle_sensor_read_sequencer #(
  parameter int QUEUE_DEPTH = sasrs_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      func,
  input  wire logic [15:0]                     rx_word,
  input  wire logic [31:0]                     now_ms,
  input  wire logic [31:0]                     now_cycles,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 tx_send,
  output logic [15:0]                          tx_word,
  output logic [3:0]                           status,
  output logic [sasrs_pkg::ANGLE_BITS-1:0]     sample_raw,
  output logic [sasrs_pkg::ANGLE_BITS-1:0]     electrical_angle,
  output logic                                 sample_valid,
  output logic [31:0]                          sequence_res,
  output logic [sasrs_pkg::ANGLE_BITS-1:0]     diag_value,
  output logic [sasrs_pkg::ANGLE_BITS-1:0]     errreg_value,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sasrs_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [sasrs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sasrs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  sasrs_pkg::cfg_t      cfg;
  sasrs_pkg::cfg_idx_t  cfg_idx;
  sasrs_pkg::q_status_t q_stat;
  sasrs_pkg::req_t      push_data;
  sasrs_pkg::req_t      pop_data;
  sasrs_pkg::res_t      res;
  logic                 push;
  logic                 pop;
  logic                 front_valid;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = sasrs_pkg::cfg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diag_period_ms <= 16'd100;
      cfg.timeout_cycles <= 32'd34000;
      cfg.pole_pairs     <= 7'd7;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        sasrs_pkg::CFG_DIAG_PERIOD: cfg.diag_period_ms <= pwdata[15:0];
        sasrs_pkg::CFG_TIMEOUT:     cfg.timeout_cycles <= pwdata[31:0];
        sasrs_pkg::CFG_POLE_PAIRS:  cfg.pole_pairs     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sasrs_pkg::CFG_DIAG_PERIOD: prdata = {16'b0, cfg.diag_period_ms};
      sasrs_pkg::CFG_TIMEOUT:     prdata = cfg.timeout_cycles;
      sasrs_pkg::CFG_POLE_PAIRS:  prdata = {25'b0, cfg.pole_pairs};
      default:                    prdata = '0;
    endcase
  end

  sasrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .rx_word     (rx_word),
    .now_ms      (now_ms),
    .now_cycles  (now_cycles),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data),
    .front_valid (front_valid)
  );

  sasrs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  sasrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (pop_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign tx_send          = res.tx_send;
  assign tx_word          = res.tx_word;
  assign status           = res.status;
  assign sample_raw       = res.sample_raw;
  assign electrical_angle = res.electrical_angle;
  assign sample_valid     = res.sample_valid;
  assign sequence_res     = res.sequence_res;
  assign diag_value       = res.diag_value;
  assign errreg_value     = res.errreg_value;

  a_fault_clears_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sasrs_pkg::ST_FAULT) |-> !sample_valid)
    else $error("sample still valid after link fault");

  a_nop_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_send) |-> (tx_word == 16'd0))
    else $error("nonzero tx_word without a frame to send");

  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    (front_valid && q_stat.full) |=> front_valid)
    else $error("front request dropped while queue full");

  a_cmd_sends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sasrs_pkg::ST_CMD) |-> (tx_send && tx_word[14]))
    else $error("command result without a read frame");

endmodule
`default_nettype wire
